>>> design/crc32bs_pkg.sv
// ----------------------------------------------------------------------------
// CRC-32 byte stream package
// Shared constants, types and the byte-advance function for the CRC-32
// (reflected, polynomial 0xEDB88320) byte stream core.
// ----------------------------------------------------------------------------
package crc32bs_pkg;

   // Number of byte lanes per transaction
   localparam int LANES = 8;
   // Byte lanes carried by the data port
   localparam int DATA_BYTES = 8;
   localparam int DATA_W = 8 * DATA_BYTES;
   localparam int COUNT_IN_W = 4;
   localparam int CRC_W = 32;

   // Saturated byte count holds 0..LANES
   localparam int CNT_W = $clog2(LANES + 1);
   // Lane index holds 0..LANES-1
   localparam int IDX_W = (LANES > 1) ? $clog2(LANES) : 1;

   localparam logic [CRC_W-1:0] CRC_POLY = 32'hEDB8_8320;
   localparam logic [CRC_W-1:0] CRC_INIT = 32'hFFFF_FFFF;

   typedef logic [LANES-1:0][CRC_W-1:0] crc_vec_type;

   // Per-lane control: saturated count and the lane's own position
   typedef struct packed {
      logic [CNT_W-1:0] count;
      logic [IDX_W-1:0] idx;
   } lane_ctl_type;

   // Advance a remainder by one zero byte: eight reflected shift steps
   function automatic logic [CRC_W-1:0] fold8(input logic [CRC_W-1:0] r_in);
      logic [CRC_W-1:0] r;
      r = r_in;
      for (int i = 0; i < 8; i++) begin
         if (r[0]) begin
            r = (r >> 1) ^ CRC_POLY;
         end else begin
            r = r >> 1;
         end
      end
      return r;
   endfunction

endpackage

>>> design/crc32bs_lane.sv
// ----------------------------------------------------------------------------
// CRC-32 byte lane
// Computes one byte's contribution to the new remainder: the byte advanced
// by the number of bytes from its lane to the end of the transaction.
// ----------------------------------------------------------------------------
module crc32bs_lane
   import crc32bs_pkg::*;
(
   input  logic [7:0]       lane_byte,
   input  lane_ctl_type     lane_ctl,
   output logic [CRC_W-1:0] lane_contrib
);

   logic [CRC_W-1:0] stage [LANES+1];
   logic [CNT_W-1:0] span;

   // Byte advanced by 0..LANES byte times
   assign stage[0] = {{(CRC_W-8){1'b0}}, lane_byte};

   for (genvar k = 1; k <= LANES; k++) begin : g_adv
      assign stage[k] = fold8(stage[k-1]);
   end

   // Distance from this lane to the end of the valid bytes
   assign span = lane_ctl.count - CNT_W'(lane_ctl.idx);

   always_comb begin
      if (lane_ctl.count > CNT_W'(lane_ctl.idx)) begin
         lane_contrib = stage[span];
      end else begin
         lane_contrib = '0;
      end
   end

endmodule

>>> design/crc32bs_merge.sv
// ----------------------------------------------------------------------------
// CRC-32 lane merge
// Advances the starting remainder by the byte count and XORs in the
// contributions of all lanes to form the new remainder.
// ----------------------------------------------------------------------------
module crc32bs_merge
   import crc32bs_pkg::*;
(
   input  logic [CRC_W-1:0] base_rem,
   input  logic [CNT_W-1:0] count,
   input  crc_vec_type      contribs,
   output logic [CRC_W-1:0] next_rem
);

   logic [CRC_W-1:0] adv [LANES+1];
   logic [CRC_W-1:0] lane_sum;

   // Remainder advanced by 0..LANES zero bytes
   assign adv[0] = base_rem;

   for (genvar k = 1; k <= LANES; k++) begin : g_adv
      assign adv[k] = fold8(adv[k-1]);
   end

   // XOR of all lane contributions
   always_comb begin
      lane_sum = '0;
      for (int j = 0; j < LANES; j++) begin
         lane_sum = lane_sum ^ contribs[j];
      end
   end

   assign next_rem = adv[count] ^ lane_sum;

endmodule

>>> design/crc32_ieee_byte_stream_core.sv
// ----------------------------------------------------------------------------
// CRC-32 byte stream core
// Reflected CRC-32 (polynomial 0xEDB88320, init all ones, final inversion)
// over a message delivered as transactions of up to eight bytes.
// ----------------------------------------------------------------------------
// The core accepts one transaction per clock. Each transaction carries up to
// eight bytes, lane 0 first; byte_count above eight counts as eight and a
// count of zero folds no bytes. start_msg reloads the remainder to all ones
// before the bytes are folded; end_msg returns the inverted remainder on the
// response channel in the cycle after acceptance. Every byte lane computes
// its contribution in parallel and a merge stage combines them with the
// advanced remainder, so the rate is set by the loop from the remainder
// register through the merge back to itself. The response sits in an output
// register; while it waits untaken, requests are held off, and they flow
// again in the cycle the receiver takes it, so with rsp_ready high the core
// runs back to back. The remainder is kept after a result, so a message
// without start_msg continues from it.
// ----------------------------------------------------------------------------
module crc32_ieee_byte_stream_core
   import crc32bs_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [DATA_W-1:0]     req_data_bytes,
   input  logic [COUNT_IN_W-1:0] req_byte_count,
   input  logic                  req_start_msg,
   input  logic                  req_end_msg,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [CRC_W-1:0]      rsp_crc_value
);

   logic [CRC_W-1:0] rem_ff;
   logic [CRC_W-1:0] rem_in;
   logic             rsp_valid_ff;
   logic             rsp_valid_in;
   logic [CRC_W-1:0] crc_ff;
   logic [CRC_W-1:0] crc_in;
   logic             req_accept;
   logic [CNT_W-1:0] cnt_sat;
   logic [CRC_W-1:0] base_rem;
   logic [CRC_W-1:0] next_rem;
   crc_vec_type      contribs;

   // Handshake: stall while an untaken result waits and is not being taken
   assign req_ready  = !rsp_valid_ff || rsp_ready;
   assign req_accept = req_valid && req_ready;

   // Saturate byte count to the lane count
   always_comb begin
      if (32'(req_byte_count) > LANES) begin
         cnt_sat = CNT_W'(LANES);
      end else begin
         cnt_sat = CNT_W'(req_byte_count);
      end
   end

   assign base_rem = req_start_msg ? CRC_INIT : rem_ff;

   // Byte lanes
   for (genvar j = 0; j < LANES; j++) begin : g_lane
      logic [7:0]   lane_byte;
      lane_ctl_type lane_ctl;

      if (j < DATA_BYTES) begin : g_data
         assign lane_byte = req_data_bytes[8*j +: 8];
      end else begin : g_zero
         assign lane_byte = 8'h00;
      end

      assign lane_ctl = {cnt_sat, IDX_W'(j)};

      crc32bs_lane u_lane (
         .lane_byte    (lane_byte),
         .lane_ctl     (lane_ctl),
         .lane_contrib (contribs[j])
      );
   end

   // Merge lanes with the advanced remainder
   crc32bs_merge u_merge (
      .base_rem (base_rem),
      .count    (cnt_sat),
      .contribs (contribs),
      .next_rem (next_rem)
   );

   // Next-state logic for remainder and response register
   always_comb begin
      rem_in       = rem_ff;
      crc_in       = crc_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (req_accept) begin
         rem_in = next_rem;
         if (req_end_msg) begin
            crc_in       = ~next_rem;
            rsp_valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rem_ff       <= CRC_INIT;
         rsp_valid_ff <= 1'b0;
      end else begin
         rem_ff       <= rem_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Response payload
   always_ff @(posedge clock) begin
      crc_ff <= crc_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_crc_value = crc_ff;

   // A finished message shows its inverted remainder
   a_result_matches_rem: assert property (@(posedge clock) disable iff (reset)
      req_accept && req_end_msg |=> rsp_valid && (rsp_crc_value == ~rem_ff))
      else $error("response does not match remainder");

   // Start with no bytes leaves the initial remainder
   a_start_empty_init: assert property (@(posedge clock) disable iff (reset)
      req_accept && req_start_msg && (req_byte_count == '0)
      |=> rem_ff == CRC_INIT)
      else $error("empty start transaction did not reload remainder");

   // Continuing transaction with no bytes keeps the remainder
   a_empty_keeps_rem: assert property (@(posedge clock) disable iff (reset)
      req_accept && !req_start_msg && (req_byte_count == '0)
      |=> rem_ff == $past(rem_ff))
      else $error("empty transaction changed remainder");

   // Stall only while a result waits
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("request stalled without a waiting response");

   // Remainder moves only on an accepted transaction
   a_rem_stable_idle: assert property (@(posedge clock) disable iff (reset)
      !req_accept |=> $stable(rem_ff))
      else $error("remainder changed without a transaction");

endmodule

>>> bench/crc32_ieee_byte_stream_core_test.sv
// ----------------------------------------------------------------------------
// CRC-32 byte stream core testbench
// Drives byte-stream transactions into the core and checks every returned CRC
// against a bit-level software fold of its bytes or a known value. A directed
// table covers reset state, count extremes and check values. Random messages
// follow, with random idle gaps on both channels and one long response stall.
// ----------------------------------------------------------------------------
module crc32_ieee_byte_stream_core_test;
   import crc32bs_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int DIRECTED_ROWS = 20;
   localparam int RANDOM_ITEMS = 500;
   localparam int HOLD_AFTER_ITEMS = 200;
   localparam int HOLD_CYCLES = 300;
   localparam int DRAIN_CYCLES = 10;

   // One row of the directed table
   typedef struct {
      logic [DATA_W-1:0]     data;
      logic [COUNT_IN_W-1:0] count;
      logic                  sop;
      logic                  eop;
      logic                  known;
      logic [CRC_W-1:0]      crc;
   } crc_row_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic [DATA_W-1:0]     req_data_bytes = '0;
   logic [COUNT_IN_W-1:0] req_byte_count = '0;
   logic                  req_start_msg = 1'b0;
   logic                  req_end_msg = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [CRC_W-1:0]      rsp_crc_value;

   // Predictor state and scoreboard
   logic [CRC_W-1:0] crc_remainder = CRC_INIT;
   logic [CRC_W-1:0] crc_expected_q[$];
   int               accepted_items = 0;
   int               fail_count = 0;
   bit               rsp_hold = 1'b0;

   crc_row_type directed_rows [DIRECTED_ROWS] = '{
      // reset state: no start, no bytes, end returns inverted all ones
      '{64'h0, 4'd0, 1'b0, 1'b1, 1'b1, 32'h0000_0000},
      '{64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 1'b1, 1'b0, 1'b0, 32'h0},
      '{64'h0, 4'd15, 1'b0, 1'b1, 1'b0, 32'h0},
      // "123456789" check value, upper lanes of the tail hold junk
      '{64'h3837_3635_3433_3231, 4'd8, 1'b1, 1'b0, 1'b0, 32'h0},
      '{64'hA5A5_A5A5_A5A5_A539, 4'd1, 1'b0, 1'b1, 1'b1, 32'hCBF4_3926},
      '{64'h0, 4'd1, 1'b1, 1'b1, 1'b1, 32'hD202_EF8D},
      '{64'hFFFF_FFFF_FFFF_FFFF, 4'd1, 1'b1, 1'b1, 1'b1, 32'hFF00_0000},
      '{64'h0, 4'd4, 1'b1, 1'b1, 1'b1, 32'h2144_DF1C},
      // start and end with zero bytes
      '{64'hDEAD_BEEF_0BAD_F00D, 4'd0, 1'b1, 1'b1, 1'b1, 32'h0000_0000},
      '{64'h0123_4567_89AB_CDEF, 4'd9, 1'b1, 1'b1, 1'b0, 32'h0},
      '{64'hFEDC_BA98_7654_3210, 4'd0, 1'b1, 1'b0, 1'b0, 32'h0},
      '{64'h1122_3344_5566_7788, 4'd3, 1'b0, 1'b0, 1'b0, 32'h0},
      '{64'h99AA_BBCC_DDEE_FF00, 4'd0, 1'b0, 1'b1, 1'b0, 32'h0},
      // continues from the remainder left by the last result
      '{64'h5A5A_5A5A_5A5A_5A5A, 4'd2, 1'b0, 1'b1, 1'b0, 32'h0},
      '{64'hC3C3_3C3C_0F0F_F0F0, 4'd5, 1'b1, 1'b0, 1'b0, 32'h0},
      '{64'h8421_1248_7E7E_8181, 4'd6, 1'b0, 1'b0, 1'b0, 32'h0},
      '{64'h0102_0408_1020_4080, 4'd7, 1'b0, 1'b1, 1'b0, 32'h0},
      '{64'hFFFF_FFFF_FFFF_FFFF, 4'd15, 1'b1, 1'b1, 1'b0, 32'h0},
      '{64'h0, 4'd12, 1'b0, 1'b1, 1'b0, 32'h0},
      '{64'h8000_0000_0000_0001, 4'd10, 1'b1, 1'b1, 1'b0, 32'h0}
   };

   crc32_ieee_byte_stream_core u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_data_bytes (req_data_bytes),
      .req_byte_count (req_byte_count),
      .req_start_msg  (req_start_msg),
      .req_end_msg    (req_end_msg),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_crc_value  (rsp_crc_value)
   );

   // 4 ns clock
   initial begin
      forever #2 clock = ~clock;
   end

   // Reflected CRC update of one byte, bit by bit
   function automatic logic [CRC_W-1:0] crc_byte_update(input logic [CRC_W-1:0] rem,
                                                         input logic [7:0] b);
      logic [CRC_W-1:0] r;
      r = rem ^ {{(CRC_W-8){1'b0}}, b};
      for (int i = 0; i < 8; i++) begin
         r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
      end
      return r;
   endfunction

   // Fold the valid lanes of one transaction; counts above LANES saturate
   function automatic logic [CRC_W-1:0] crc_item_update(input logic [CRC_W-1:0] rem,
                                                         input logic [DATA_W-1:0] data,
                                                         input logic [COUNT_IN_W-1:0] count);
      logic [CRC_W-1:0] r;
      int               n;
      logic [7:0]       b;
      r = rem;
      n = (int'(count) > LANES) ? LANES : int'(count);
      for (int k = 0; k < n; k++) begin
         b = (k < DATA_BYTES) ? data[8*k +: 8] : 8'h00;
         r = crc_byte_update(r, b);
      end
      return r;
   endfunction

   // Mostly short gaps, a few long ones
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Count field: mostly full words, some partial, zero and oversized
   function automatic logic [COUNT_IN_W-1:0] pick_count();
      int r;
      r = $urandom_range(0, 99);
      if (r < 8) return '0;
      if (r < 18) return COUNT_IN_W'($urandom_range(LANES + 1, (1 << COUNT_IN_W) - 1));
      if (r < 60) return COUNT_IN_W'(LANES);
      return COUNT_IN_W'($urandom_range(1, LANES - 1));
   endfunction

   // Offer one transaction, wait for acceptance, then update the prediction
   task automatic send_item(input logic [DATA_W-1:0] data,
                            input logic [COUNT_IN_W-1:0] count,
                            input logic sop,
                            input logic eop,
                            input logic known,
                            input logic [CRC_W-1:0] known_crc);
      logic [CRC_W-1:0] rem_next;
      req_valid      <= 1'b1;
      req_data_bytes <= data;
      req_byte_count <= count;
      req_start_msg  <= sop;
      req_end_msg    <= eop;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      rem_next = crc_item_update(sop ? CRC_INIT : crc_remainder, data, count);
      crc_remainder = rem_next;
      if (eop) begin
         crc_expected_q.push_back(known ? known_crc : ~rem_next);
      end
      accepted_items++;
   endtask

   // Drop valid for a number of cycles; no gap while the response side is held
   task automatic sender_idle(input int gap);
      if (gap > 0 && !rsp_hold) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Stimulus: directed table, then random messages
   initial begin
      int               sent;
      int               msg_len;
      bit               no_gaps;
      logic             sop;
      logic             eop;
      logic [DATA_W-1:0] data;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i]) begin
         send_item(directed_rows[i].data, directed_rows[i].count, directed_rows[i].sop,
                   directed_rows[i].eop, directed_rows[i].known, directed_rows[i].crc);
         sender_idle(pick_gap());
      end

      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         no_gaps = ($urandom_range(0, 3) == 0);
         if ($urandom_range(0, 99) < 8) begin
            // noise: a transaction with every field random
            data = {$urandom, $urandom};
            send_item(data, COUNT_IN_W'($urandom), 1'($urandom), 1'($urandom), 1'b0, '0);
            sent++;
            if (!no_gaps) sender_idle(pick_gap());
         end else begin
            msg_len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 20)
                                                  : $urandom_range(1, 8);
            for (int j = 0; j < msg_len; j++) begin
               sop = (j == 0) ? ($urandom_range(0, 9) != 0) : 1'b0;
               eop = (j == msg_len - 1);
               // occasionally a broken message with stray flags
               if (j != 0 && j != msg_len - 1 && $urandom_range(0, 19) == 0) begin
                  sop = 1'($urandom);
                  eop = 1'($urandom);
               end
               data = {$urandom, $urandom};
               send_item(data, pick_count(), sop, eop, 1'b0, '0);
               sent++;
               if (!no_gaps) sender_idle(pick_gap());
            end
         end
      end
      req_valid <= 1'b0;

      // drain the scoreboard, then allow stray responses to show up
      while (crc_expected_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("** crc32_ieee_byte_stream_core: PASSED **");
      end else begin
         $display("** crc32_ieee_byte_stream_core: FAILED **");
      end
      $finish;
   end

   // Response side: random ready with one long hold
   initial begin
      int  n;
      bit  hold_done;
      hold_done = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (!hold_done && accepted_items >= HOLD_AFTER_ITEMS) begin
            rsp_ready <= 1'b0;
            rsp_hold = 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            rsp_hold = 1'b0;
            hold_done = 1'b1;
         end
         n = $urandom_range(1, 12);
         rsp_ready <= 1'b1;
         repeat (n) @(posedge clock);
         n = pick_gap();
         if (n > 0) begin
            rsp_ready <= 1'b0;
            repeat (n) @(posedge clock);
         end
      end
   end

   // Check each returned CRC against the oldest expectation
   always @(posedge clock) begin
      logic [CRC_W-1:0] crc_exp;
      if (!reset && rsp_valid && rsp_ready) begin
         if (crc_expected_q.size() == 0) begin
            $error("crc_value: unexpected transaction, actual %08h", rsp_crc_value);
            fail_count++;
         end else begin
            crc_exp = crc_expected_q.pop_front();
            if (rsp_crc_value !== crc_exp) begin
               $error("crc_value: expected %08h, actual %08h", crc_exp, rsp_crc_value);
               fail_count++;
            end
         end
      end
   end

   // Run limit
   initial begin
      #2_000_000;
      $display("** crc32_ieee_byte_stream_core: FAILED **");
      $finish;
   end

endmodule
